// ===== design/rit_pkg.sv =====
package rit_pkg;

  // Command codes carried on the opcode field
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2,
    OP_RESET = 2'd3
  } op_t;

  // Configuration register indexes
  localparam int unsigned CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] CFG_DURATION       = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LOOP_ENABLE    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_LIMITED_ENABLE = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_FIXED_ENABLE   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_USE_UNSCALED   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_LOOPS      = 3'd5;

  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned DELTA_W     = 32;
  localparam int unsigned ELAPSED_W   = 32;
  localparam int unsigned REMAINING_W = 33;
  localparam int unsigned LOOPS_W     = 16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TRIG,
    ST_OUT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;   // execute the accepted command
    logic trig;   // apply one trigger
  } rit_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic tick_go;   // accepted opcode is a tick on an active timer
    logic ge;        // elapsed >= duration for the current elapsed
    logic more;      // the trigger being applied keeps the timer looping
    logic ge_after;  // elapsed after this trigger still reaches duration
    logic fixed;     // fixed-interval catch-up enabled
  } rit_status_t;

endpackage

// ===== design/rit_ctrl.sv =====
module rit_ctrl #(
  parameter int unsigned MAX_CATCHUP = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  output logic                 cmd_ready,
  output logic                 res_valid,
  input  logic                 res_ready,
  output logic                 fired,
  output logic                 last,
  output rit_pkg::rit_cmd_t    cmd,
  input  rit_pkg::rit_status_t status
);
  import rit_pkg::*;

  localparam int unsigned CW = $clog2(MAX_CATCHUP + 1);

  state_t         state;
  state_t         state_next;
  logic           fired_next;
  logic           last_next;
  logic [CW-1:0]  count;
  logic [CW-1:0]  count_next;
  logic           accept;
  logic           trig_last;

  assign accept = cmd_valid && cmd_ready;

  // A trigger ends the burst when the mode stops, catch-up is off,
  // the time left no longer reaches duration or the cap is reached.
  assign trig_last = !status.fixed || !status.more || !status.ge_after ||
                     (count == CW'(MAX_CATCHUP - 1));

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = status.tick_go ? ST_TRIG : ST_OUT;
        end
      end
      ST_TRIG: state_next = ST_OUT;
      ST_OUT: begin
        if (res_ready) begin
          state_next = last ? ST_IDLE : ST_TRIG;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_ready  = 1'b0;
    res_valid  = 1'b0;
    cmd.load   = 1'b0;
    cmd.trig   = 1'b0;
    fired_next = fired;
    last_next  = last;
    count_next = count;
    case (state)
      ST_IDLE: begin
        cmd_ready = 1'b1;
        if (accept) begin
          cmd.load   = 1'b1;
          fired_next = 1'b0;
          last_next  = 1'b1;
          count_next = '0;
        end
      end
      ST_TRIG: begin
        if (status.ge) begin
          cmd.trig   = 1'b1;
          fired_next = 1'b1;
          last_next  = trig_last;
          count_next = count + 1'b1;
        end else begin
          fired_next = 1'b0;
          last_next  = 1'b1;
        end
      end
      ST_OUT: res_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      fired <= 1'b0;
      last  <= 1'b0;
      count <= '0;
    end else begin
      state <= state_next;
      fired <= fired_next;
      last  <= last_next;
      count <= count_next;
    end
  end

endmodule

// ===== design/rit_datapath.sv =====
module rit_datapath #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_write,
  input  logic [rit_pkg::CFG_INDEX_W-1:0]         cfg_index,
  input  logic [rit_pkg::CFG_DATA_W-1:0]          cfg_data,
  input  logic [1:0]                              opcode,
  input  logic [rit_pkg::DELTA_W-1:0]             scaled_delta,
  input  logic [rit_pkg::DELTA_W-1:0]             unscaled_delta,
  input  rit_pkg::rit_cmd_t                       cmd,
  output rit_pkg::rit_status_t                    status,
  output logic                                    running,
  output logic                                    finished,
  output logic [rit_pkg::ELAPSED_W-1:0]           elapsed,
  output logic signed [rit_pkg::REMAINING_W-1:0]  remaining,
  output logic [rit_pkg::LOOPS_W-1:0]             loops_done
);
  import rit_pkg::*;

  localparam int unsigned TW = TIME_WIDTH;
  localparam int unsigned DW = (TW > 32) ? TW : 32;

  // Configuration
  logic [CFG_DATA_W-1:0] duration;
  logic                  loop_enable;
  logic                  limited_enable;
  logic                  fixed_enable;
  logic                  use_unscaled;
  logic [LOOPS_W-1:0]    max_loops;

  // Timer state
  logic [TW-1:0]         elapsed_time;
  logic [LOOPS_W-1:0]    loop_counter;
  logic                  ge;

  logic [DW-1:0]         dur_wide;
  logic [TW-1:0]         dur;
  logic [DW-1:0]         delta_wide;
  logic [TW-1:0]         delta;
  logic [TW:0]           sum;
  logic [TW-1:0]         sum_sat;
  logic [TW-1:0]         diff;
  logic [LOOPS_W-1:0]    count_inc;
  logic                  stop_now;
  logic                  looping;
  logic [DW-1:0]         elapsed_wide;
  logic [DW:0]           rem_full;

  assign dur_wide   = DW'(duration);
  assign dur        = dur_wide[TW-1:0];
  assign delta_wide = DW'(use_unscaled ? unscaled_delta : scaled_delta);
  assign delta      = delta_wide[TW-1:0];

  // Saturating add of the step
  assign sum     = {1'b0, elapsed_time} + {1'b0, delta};
  assign sum_sat = sum[TW] ? {TW{1'b1}} : sum[TW-1:0];

  // One period back; only used when elapsed >= duration
  assign diff = elapsed_time - dur;

  assign count_inc = (loop_counter == {LOOPS_W{1'b1}}) ? loop_counter
                                                       : loop_counter + 1'b1;
  assign stop_now  = limited_enable && (count_inc >= max_loops);
  assign looping   = loop_enable || limited_enable;

  assign status.tick_go  = (op_t'(opcode) == OP_TICK) && running && !finished;
  assign status.ge       = ge;
  assign status.more     = !stop_now && looping;
  assign status.ge_after = diff >= dur;
  assign status.fixed    = fixed_enable;

  assign elapsed_wide = DW'(elapsed_time);
  assign elapsed      = elapsed_wide[ELAPSED_W-1:0];
  assign rem_full     = (DW + 1)'(dur) - (DW + 1)'(elapsed_time);
  assign remaining    = $signed(rem_full[REMAINING_W-1:0]);
  assign loops_done   = loop_counter;

  always_ff @(posedge clk) begin
    if (rst) begin
      duration       <= '0;
      loop_enable    <= 1'b0;
      limited_enable <= 1'b0;
      fixed_enable   <= 1'b0;
      use_unscaled   <= 1'b0;
      max_loops      <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_DURATION:       duration       <= cfg_data;
        CFG_LOOP_ENABLE:    loop_enable    <= cfg_data[0];
        CFG_LIMITED_ENABLE: limited_enable <= cfg_data[0];
        CFG_FIXED_ENABLE:   fixed_enable   <= cfg_data[0];
        CFG_USE_UNSCALED:   use_unscaled   <= cfg_data[0];
        CFG_MAX_LOOPS:      max_loops      <= cfg_data[LOOPS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed_time <= '0;
      loop_counter <= '0;
      running      <= 1'b0;
      finished     <= 1'b0;
      ge           <= 1'b0;
    end else if (cmd.load) begin
      case (op_t'(opcode))
        OP_START: begin
          elapsed_time <= '0;
          loop_counter <= '0;
          running      <= 1'b1;
          finished     <= 1'b0;
        end
        OP_STOP: running <= 1'b0;
        OP_RESET: begin
          elapsed_time <= '0;
          loop_counter <= '0;
          running      <= 1'b0;
          finished     <= 1'b0;
        end
        OP_TICK: begin
          if (status.tick_go) begin
            elapsed_time <= sum_sat;
            ge           <= sum_sat >= dur;
          end
        end
        default: ;
      endcase
    end else if (cmd.trig) begin
      loop_counter <= count_inc;
      if (stop_now) begin
        finished <= 1'b1;
        running  <= 1'b0;
      end else if (looping) begin
        elapsed_time <= diff;
        ge           <= status.ge_after;
      end else begin
        finished     <= 1'b1;
        running      <= 1'b0;
        elapsed_time <= dur;
      end
    end
  end

endmodule

// ===== design/repeating_interval_timer.sv =====
// Repeating interval timer with one-shot, loop, limited-loop and
// fixed-interval catch-up modes.
//
// Channels: commands enter on cmd_valid/cmd_ready with opcode (tick, start,
// stop, reset) and the scaled and unscaled Q16.16 steps. Results leave on
// res_valid/res_ready, one transaction per trigger, or a single status
// transaction with fired low when a command causes no trigger; last marks
// the final result of a command. The user must write configuration through
// cfg_write/cfg_index/cfg_data only with no command in flight; unenforced.
//
// Sequencing: start, stop, reset and ticks on an idle timer show their
// result in the cycle after acceptance. A tick on a running timer adds the
// step at acceptance and passes through a trigger state, which applies a
// trigger (or finds none), before each result: first after acceptance and
// again after each taken result for every further catch-up trigger. At most
// MAX_CATCHUP results per tick; the next command is taken the cycle after
// the last result.
//
// Reset clears the configuration and the timer state. When the receiver
// stalls, the result and the timer state hold until res_ready rises.
module repeating_interval_timer #(
  parameter int unsigned MAX_CATCHUP = 16,
  parameter int unsigned TIME_WIDTH  = 32
) (
  input  logic                                    clk,
  input  logic                                    rst,
  // Configuration port
  input  logic                                    cfg_write,
  input  logic [rit_pkg::CFG_INDEX_W-1:0]         cfg_index,
  input  logic [rit_pkg::CFG_DATA_W-1:0]          cfg_data,
  // Command channel
  input  logic                                    cmd_valid,
  output logic                                    cmd_ready,
  input  logic [1:0]                              opcode,
  input  logic [rit_pkg::DELTA_W-1:0]             scaled_delta,
  input  logic [rit_pkg::DELTA_W-1:0]             unscaled_delta,
  // Result channel
  output logic                                    res_valid,
  input  logic                                    res_ready,
  output logic                                    fired,
  output logic                                    last,
  output logic                                    running,
  output logic                                    finished,
  output logic [rit_pkg::ELAPSED_W-1:0]           elapsed,
  output logic signed [rit_pkg::REMAINING_W-1:0]  remaining,
  output logic [rit_pkg::LOOPS_W-1:0]             loops_done
);
  import rit_pkg::*;

  rit_cmd_t    cmd;
  rit_status_t status;

  // Sequence commands, triggers and result handshakes
  rit_ctrl #(
    .MAX_CATCHUP (MAX_CATCHUP)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .fired     (fired),
    .last      (last),
    .cmd       (cmd),
    .status    (status)
  );

  // Hold configuration and timer state; the status fields of a result are
  // read straight from that state, which stays frozen while a result waits.
  rit_datapath #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .opcode         (opcode),
    .scaled_delta   (scaled_delta),
    .unscaled_delta (unscaled_delta),
    .cmd            (cmd),
    .status         (status),
    .running        (running),
    .finished       (finished),
    .elapsed        (elapsed),
    .remaining      (remaining),
    .loops_done     (loops_done)
  );

endmodule

// ===== design/rit_checker.sv =====
module rit_checker (
  input logic                                    clk,
  input logic                                    rst,
  input logic                                    cmd_valid,
  input logic                                    cmd_ready,
  input logic                                    res_valid,
  input logic                                    res_ready,
  input logic                                    fired,
  input logic                                    last,
  input logic                                    running,
  input logic                                    finished,
  input logic [rit_pkg::ELAPSED_W-1:0]           elapsed,
  input logic signed [rit_pkg::REMAINING_W-1:0]  remaining,
  input logic [rit_pkg::LOOPS_W-1:0]             loops_done
);

  // A stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(fired) && $stable(last) &&
      $stable(elapsed) && $stable(remaining) && $stable(loops_done))
    else $error("result changed while stalled");

  // No new command while a result is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(res_valid && cmd_ready))
    else $error("command taken while result pending");

  // A result without a trigger closes its command
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && !fired |-> last)
    else $error("non-trigger result not marked last");

  // A result never shows a finished timer as running
  a_fin_idle: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(running && finished))
    else $error("running and finished together");

  // A finishing trigger ends the burst
  a_fin_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && fired && finished |-> last)
    else $error("results continue after finish");

endmodule

bind repeating_interval_timer rit_checker u_rit_checker (.*);

// ===== sim/timer_result_checker.sv =====
module timer_result_checker
  import rit_pkg::*;
#(
  parameter int unsigned MAX_CATCHUP = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [CFG_INDEX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]           cfg_data,
  input  logic                            cmd_valid,
  input  logic                            cmd_ready,
  input  logic [1:0]                      opcode,
  input  logic [DELTA_W-1:0]              scaled_delta,
  input  logic [DELTA_W-1:0]              unscaled_delta,
  input  logic                            res_valid,
  input  logic                            res_ready,
  input  logic                            fired,
  input  logic                            last,
  input  logic                            running,
  input  logic                            finished,
  input  logic [ELAPSED_W-1:0]            elapsed,
  input  logic signed [REMAINING_W-1:0]   remaining,
  input  logic [LOOPS_W-1:0]              loops_done,
  output int unsigned                     failures,
  output int unsigned                     outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    bit                   fired;
    bit                   last;
    bit                   running;
    bit                   finished;
    bit [ELAPSED_W-1:0]   elapsed;
    bit [REMAINING_W-1:0] remaining;
    bit [LOOPS_W-1:0]     loops_done;
  } timer_report_t;

  timer_report_t pending_reports[$];

  // Register copies
  logic [31:0] dur_c;
  logic        loop_c, lim_c, fix_c, unsc_c;
  logic [15:0] maxl_c;

  // Timer state copies
  logic [31:0] elapsed_q;
  logic [15:0] loops_q;
  logic        run_q, fin_q;

  task automatic flag_mismatch(string what);
    failures++;
    if (failures <= 200) $display("%0t ns  MISMATCH  %s", $time, what);
  endtask

  task automatic check_field(string name, logic [32:0] got, logic [32:0] want);
    if (got !== want)
      flag_mismatch($sformatf("%s: got %0h, predicted %0h", name, got, want));
  endtask

  // Apply one trigger; return 1 while the timer keeps looping.
  function automatic bit apply_trigger();
    if (loops_q != 16'hFFFF) loops_q++;
    if (lim_c && loops_q >= maxl_c) begin
      fin_q = 1'b1;
      run_q = 1'b0;
      return 1'b0;
    end
    if (loop_c || lim_c) begin
      elapsed_q = elapsed_q - dur_c;
      return 1'b1;
    end
    fin_q     = 1'b1;
    run_q     = 1'b0;
    elapsed_q = dur_c;
    return 1'b0;
  endfunction

  function automatic void log_report(bit hit);
    timer_report_t r;
    r.fired      = hit;
    r.last       = 1'b0;
    r.running    = run_q;
    r.finished   = fin_q;
    r.elapsed    = elapsed_q;
    r.remaining  = {1'b0, dur_c} - {1'b0, elapsed_q};
    r.loops_done = loops_q;
    pending_reports.push_back(r);
  endfunction

  function automatic void step_timer(op_t op, logic [31:0] sd, logic [31:0] ud);
    int unsigned n;
    logic [32:0] sum;
    bit          more;
    n = 0;
    case (op)
      OP_START: begin
        loops_q   = '0;
        elapsed_q = '0;
        run_q     = 1'b1;
        fin_q     = 1'b0;
      end
      OP_STOP: run_q = 1'b0;
      OP_RESET: begin
        elapsed_q = '0;
        loops_q   = '0;
        run_q     = 1'b0;
        fin_q     = 1'b0;
      end
      default: begin
        if (run_q && !fin_q) begin
          sum       = {1'b0, elapsed_q} + {1'b0, (unsc_c ? ud : sd)};
          elapsed_q = sum[32] ? '1 : sum[31:0];
          if (fix_c) begin
            while (n < MAX_CATCHUP && elapsed_q >= dur_c) begin
              more = apply_trigger();
              log_report(1'b1);
              n++;
              if (!more) break;
            end
          end else if (elapsed_q >= dur_c) begin
            void'(apply_trigger());
            log_report(1'b1);
            n++;
          end
        end
      end
    endcase
    if (n == 0) log_report(1'b0);
    pending_reports[pending_reports.size() - 1].last = 1'b1;
  endfunction

  always @(posedge clk) begin
    timer_report_t want;
    if (rst) begin
      dur_c     = '0;
      loop_c    = 1'b0;
      lim_c     = 1'b0;
      fix_c     = 1'b0;
      unsc_c    = 1'b0;
      maxl_c    = '0;
      elapsed_q = '0;
      loops_q   = '0;
      run_q     = 1'b0;
      fin_q     = 1'b0;
      failures  = 0;
      pending_reports.delete();
    end else begin
      if (res_valid && res_ready) begin
        if (pending_reports.size() == 0) begin
          flag_mismatch("result transaction with nothing predicted");
        end else begin
          want = pending_reports.pop_front();
          check_field("fired",      33'(fired),      33'(want.fired));
          check_field("last",       33'(last),       33'(want.last));
          check_field("running",    33'(running),    33'(want.running));
          check_field("finished",   33'(finished),   33'(want.finished));
          check_field("elapsed",    33'(elapsed),    33'(want.elapsed));
          check_field("remaining",  33'(remaining),  want.remaining);
          check_field("loops_done", 33'(loops_done), 33'(want.loops_done));
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          CFG_DURATION:       dur_c  = cfg_data;
          CFG_LOOP_ENABLE:    loop_c = cfg_data[0];
          CFG_LIMITED_ENABLE: lim_c  = cfg_data[0];
          CFG_FIXED_ENABLE:   fix_c  = cfg_data[0];
          CFG_USE_UNSCALED:   unsc_c = cfg_data[0];
          CFG_MAX_LOOPS:      maxl_c = cfg_data[15:0];
          default: ;
        endcase
      end
      if (cmd_valid && cmd_ready)
        step_timer(op_t'(opcode), scaled_delta, unscaled_delta);
    end
    outstanding <= pending_reports.size();
  end

endmodule

// ===== sim/repeating_interval_timer_tb.sv =====
module repeating_interval_timer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rit_pkg::*;

  localparam int unsigned MAX_CATCHUP = 16;
  localparam int unsigned TIME_WIDTH  = 32;

  logic                          clk;
  logic                          rst            = 1'b1;
  logic                          cfg_write      = 1'b0;
  logic [CFG_INDEX_W-1:0]        cfg_index      = CFG_DURATION;
  logic [CFG_DATA_W-1:0]         cfg_data       = '0;
  logic                          cmd_valid      = 1'b0;
  logic                          cmd_ready;
  logic [1:0]                    opcode         = OP_TICK;
  logic [DELTA_W-1:0]            scaled_delta   = '0;
  logic [DELTA_W-1:0]            unscaled_delta = '0;
  logic                          res_valid;
  logic                          res_ready      = 1'b0;
  logic                          fired, last, running, finished;
  logic [ELAPSED_W-1:0]          elapsed;
  logic signed [REMAINING_W-1:0] remaining;
  logic [LOOPS_W-1:0]            loops_done;

  int unsigned failures;
  int unsigned outstanding;

  // Chance, in percent, that the sender idles or the receiver stalls in a cycle
  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;

  repeating_interval_timer #(
    .MAX_CATCHUP (MAX_CATCHUP),
    .TIME_WIDTH  (TIME_WIDTH)
  ) dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .cmd_valid      (cmd_valid),
    .cmd_ready      (cmd_ready),
    .opcode         (opcode),
    .scaled_delta   (scaled_delta),
    .unscaled_delta (unscaled_delta),
    .res_valid      (res_valid),
    .res_ready      (res_ready),
    .fired          (fired),
    .last           (last),
    .running        (running),
    .finished       (finished),
    .elapsed        (elapsed),
    .remaining      (remaining),
    .loops_done     (loops_done)
  );

  // Predicts every result transaction and compares it field by field
  timer_result_checker #(
    .MAX_CATCHUP (MAX_CATCHUP)
  ) results_chk (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .cmd_valid      (cmd_valid),
    .cmd_ready      (cmd_ready),
    .opcode         (opcode),
    .scaled_delta   (scaled_delta),
    .unscaled_delta (unscaled_delta),
    .res_valid      (res_valid),
    .res_ready      (res_ready),
    .fired          (fired),
    .last           (last),
    .running        (running),
    .finished       (finished),
    .elapsed        (elapsed),
    .remaining      (remaining),
    .loops_done     (loops_done),
    .failures       (failures),
    .outstanding    (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop: far beyond the slowest legal run, with every tick bursting
  // MAX_CATCHUP results under worst-case stalls on every one of them.
  initial begin
    #4_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // Receiver: drop ready at random with the current stall rate
  always @(posedge clk) begin
    res_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Offer one command transaction and hold it until accepted. Valid stays
  // high across back-to-back transactions; it drops only in an idle gap or a drain.
  task automatic send_cmd(op_t op, logic [31:0] sd, logic [31:0] ud);
    while ($urandom_range(99) < idle_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid      <= 1'b1;
    opcode         <= op;
    scaled_delta   <= sd;
    unscaled_delta <= ud;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
  endtask

  // Drop valid and hold off until every predicted result has arrived
  task automatic drain();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Write all six registers, one per cycle; call only while drained
  task automatic load_config(logic [31:0] dur, bit lp, bit lim, bit fix, bit unsc,
                             logic [15:0] maxl);
    logic [CFG_INDEX_W-1:0] idx [6];
    logic [CFG_DATA_W-1:0]  val [6];
    idx = '{CFG_DURATION, CFG_LOOP_ENABLE, CFG_LIMITED_ENABLE, CFG_FIXED_ENABLE,
            CFG_USE_UNSCALED, CFG_MAX_LOOPS};
    val = '{dur, 32'(lp), 32'(lim), 32'(fix), 32'(unsc), 32'(maxl)};
    for (int i = 0; i < 6; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
    end
    cfg_write <= 1'b0;
  endtask

  // Pick a step that lands near interesting multiples of the period,
  // plus zero, all-ones and fully random steps.
  function automatic logic [31:0] pick_delta(logic [31:0] dur);
    logic [63:0] w;
    case ($urandom_range(5))
      0: w = '0;
      1: w = 64'($urandom);
      2: w = 64'hFFFF_FFFF;
      3: w = 64'(dur) / 64'($urandom_range(1, 4));
      4: w = 64'(dur) * 64'($urandom_range(1, 20));
      default: w = 64'($urandom_range(0, 32'h0003_0000));
    endcase
    return (w > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : w[31:0];
  endfunction

  initial begin
    logic [31:0] dur;
    logic [15:0] maxl;
    op_t         op;
    int unsigned ticks_left;
    int unsigned r;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- Directed part, no idling ----
    // One-shot, scaled step, 3 s period
    load_config(32'h0003_0000, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0);
    send_cmd(OP_TICK,  32'hFFFF_FFFF, 32'h0000_0000);  // tick while stopped
    send_cmd(OP_START, 32'h0000_0000, 32'hFFFF_FFFF);
    send_cmd(OP_TICK,  32'h0001_0000, 32'hFFFF_FFFF);  // 1 s, no trigger
    send_cmd(OP_TICK,  32'hFFFF_FFFF, 32'h0000_0000);  // saturate, fire, clamp
    send_cmd(OP_TICK,  32'h0001_0000, 32'h0001_0000);  // finished: status only
    send_cmd(OP_STOP,  32'h0000_0000, 32'h0000_0000);
    send_cmd(OP_RESET, 32'h0000_0000, 32'h0000_0000);
    drain();

    // Both loop bits set: limited loop wins; zero count ends on first trigger
    load_config(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, 1'b1, 16'd0);
    send_cmd(OP_START, 32'h0000_0000, 32'h0000_0000);
    send_cmd(OP_TICK,  32'h0000_0000, 32'hFFFF_FFFF);
    send_cmd(OP_TICK,  32'h0000_0000, 32'hFFFF_FFFF);
    drain();

    // Fixed-interval catch-up: 20 periods in one step, bounded at MAX_CATCHUP
    load_config(32'h0001_0000, 1'b1, 1'b0, 1'b1, 1'b0, 16'd0);
    send_cmd(OP_START, 32'h0000_0000, 32'h0000_0000);
    send_cmd(OP_TICK,  32'h0014_0000, 32'h0000_0000);
    send_cmd(OP_TICK,  32'h0000_0000, 32'hFFFF_FFFF);  // surplus fires now
    send_cmd(OP_STOP,  32'h0000_0000, 32'h0000_0000);
    send_cmd(OP_TICK,  32'h0005_0000, 32'h0000_0000);  // stopped: no trigger
    drain();

    // Limited catch-up ends mid-burst
    load_config(32'h0000_8000, 1'b0, 1'b1, 1'b1, 1'b0, 16'd3);
    send_cmd(OP_START, 32'h0000_0000, 32'h0000_0000);
    send_cmd(OP_TICK,  32'h0010_0000, 32'h0000_0000);
    drain();

    // Zero period, plain loop: every tick fires once
    load_config(32'h0000_0000, 1'b1, 1'b0, 1'b0, 1'b0, 16'd0);
    send_cmd(OP_START, 32'h0000_0000, 32'h0000_0000);
    send_cmd(OP_TICK,  32'h0000_0000, 32'h0000_0000);
    send_cmd(OP_TICK,  32'h0000_0000, 32'h0000_0000);
    drain();

    // All registers at their top values
    load_config(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b1, 16'hFFFF);
    send_cmd(OP_START, 32'h0000_0000, 32'h0000_0000);
    send_cmd(OP_TICK,  32'h0000_0000, 32'hFFFF_FFFF);
    send_cmd(OP_RESET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    drain();

    // ---- Random part: eight phases, each with its own settings ----
    for (int ph = 0; ph < 8; ph++) begin
      drain();
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 77; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 77; end
        default: begin idle_pct = 34; stall_pct = 34; end
      endcase
      case ($urandom_range(4))
        0: dur = 32'h0000_0000;
        1: dur = 32'hFFFF_FFFF;
        2: dur = 32'h0001_0000;
        3: dur = $urandom_range(1, 32'h0004_0000);
        default: dur = $urandom;
      endcase
      case ($urandom_range(3))
        0: maxl = 16'd0;
        1: maxl = 16'($urandom_range(1, 8));
        2: maxl = 16'hFFFF;
        default: maxl = 16'($urandom);
      endcase
      load_config(dur, 1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom), maxl);

      // Mostly start followed by a run of ticks; the rest is stray commands
      ticks_left = 0;
      for (int k = 0; k < 41; k++) begin
        if (ticks_left == 0) begin
          r = $urandom_range(99);
          if (r < 65) begin
            op         = OP_START;
            ticks_left = $urandom_range(1, 10);
          end else if (r < 75) op = OP_STOP;
          else if (r < 85)     op = OP_RESET;
          else                 op = OP_TICK;
        end else begin
          if ($urandom_range(19) == 0) op = OP_STOP;
          else                         op = OP_TICK;
          ticks_left--;
        end
        // Now and then, let the block empty out completely first
        if ($urandom_range(24) == 0) drain();
        send_cmd(op, pick_delta(dur), pick_delta(dur));
      end
    end

    // ---- Wind down ----
    drain();
    repeat (8) @(posedge clk);
    if (failures == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
